FILE: hw/rtl/lhsm_pkg.sv
// Shared constants, types and helpers of the latency histogram statistics monitor.
package lhsm_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int NUM_PHASES  = 3;
  localparam int PHASE_W     = 2;
  localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int HIST_DEPTH  = NUM_PHASES * NUM_BUCKETS;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  // bucket sum of one phase
  localparam int TOT_W       = 32 + BKT_W;
  localparam int DIV_N_W     = (TOT_W + 7 > 49) ? TOT_W + 7 : 49;
  localparam int DIV_D_W     = 32;
  localparam int PCT_SCALE   = 100;
  localparam int DIV_CNT_W   = $clog2(DIV_N_W + 1);

  localparam logic REG_BUCKET_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_QUERY,
    OP_EMPTY
  } op_e;

  typedef struct packed {
    op_e                kind;
    logic [PHASE_W-1:0] phase;
    logic [31:0]        sample_time;
    logic [6:0]         pct;
    logic [BKT_W-1:0]   bucket;
  } lhsm_op_t;

  function automatic logic [15:0] eff_width(logic [15:0] w);
    return (w == 16'd0) ? 16'd1 : w;
  endfunction

  function automatic logic [HIST_AW-1:0] hist_addr(logic [PHASE_W-1:0] ph,
                                                   logic [BKT_W-1:0] idx);
    return HIST_AW'(ph) * HIST_AW'(NUM_BUCKETS) + HIST_AW'(idx);
  endfunction

endpackage

FILE: hw/rtl/lhsm_in_if.sv
// Request channel carrying one record or query request.
interface lhsm_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  phase;
  logic [31:0] sample_time;
  logic [6:0]  percentile_pct;

  modport source (output valid, action, phase, sample_time, percentile_pct, input ready);
  modport sink (input valid, action, phase, sample_time, percentile_pct, output ready);
endinterface

FILE: hw/rtl/lhsm_out_if.sv
// Result channel carrying the statistics of one phase.
interface lhsm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_count;
  logic [47:0] time_total;
  logic [31:0] time_min;
  logic [31:0] time_max;
  logic [47:0] mean_q16;
  logic [63:0] sq_dev_sum_q8;
  logic [31:0] percentile_time;

  modport source (output valid, sample_count, time_total, time_min, time_max, mean_q16,
                  sq_dev_sum_q8, percentile_time, input ready);
  modport sink (input valid, sample_count, time_total, time_min, time_max, mean_q16,
                sq_dev_sum_q8, percentile_time, output ready);
endinterface

FILE: hw/rtl/lhsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lhsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hw/rtl/lhsm_div.sv
// Restoring divider, one quotient bit per cycle.
module lhsm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lhsm_pkg::DIV_N_W-1:0] num_i,
  input  logic [lhsm_pkg::DIV_D_W-1:0] den_i,
  output logic                        done_o,
  output logic [lhsm_pkg::DIV_N_W-1:0] quo_o
);
  import lhsm_pkg::*;

  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W:0]     rem_q, rem_d;
  logic [DIV_D_W-1:0]   den_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_D_W:0]     shifted;
  logic                 fits;

  always_comb begin
    shifted = {rem_q[DIV_D_W-1:0], quo_q[DIV_N_W-1]};
    fits    = shifted >= {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_N_W-2:0], fits};
      rem_d = fits ? shifted - {1'b0, den_q} : shifted;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

FILE: hw/rtl/lhsm_front.sv
// Front end: accepts requests, classifies them and computes the histogram bucket.
module lhsm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               init_done_i,
  input  logic [15:0]        eff_width_i,
  lhsm_in_if.sink            in_i,
  output logic               push_o,
  output lhsm_pkg::lhsm_op_t op_o,
  input  logic               full_i
);
  import lhsm_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIVS, F_DIVW, F_PUSH} fstate_e;

  fstate_e            state_q;
  lhsm_op_t           op_q;
  logic               take;
  logic               div_done;
  logic [DIV_N_W-1:0] div_quo;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic [BKT_W-1:0]   bucket;

  assign in_i.ready = (state_q == F_IDLE) && init_done_i;
  assign take       = in_i.valid && in_i.ready;

  // round(t / w) = (2t + w) / 2w
  assign div_num = DIV_N_W'({1'b0, op_q.sample_time, 1'b0}) + DIV_N_W'(eff_width_i);
  assign div_den = DIV_D_W'({eff_width_i, 1'b0});
  assign bucket  = (div_quo >= DIV_N_W'(NUM_BUCKETS)) ? BKT_W'(NUM_BUCKETS - 1)
                                                       : div_quo[BKT_W-1:0];

  lhsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == F_DIVS),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (take) begin
            op_q.phase       <= in_i.phase;
            op_q.sample_time <= in_i.sample_time;
            op_q.pct         <= in_i.percentile_pct;
            op_q.bucket      <= '0;
            if (in_i.phase >= PHASE_W'(NUM_PHASES)) begin
              op_q.kind <= OP_EMPTY;
              state_q   <= F_PUSH;
            end else if (in_i.action) begin
              op_q.kind <= OP_QUERY;
              state_q   <= F_PUSH;
            end else begin
              op_q.kind <= OP_RECORD;
              state_q   <= F_DIVS;
            end
          end
        end
        F_DIVS: state_q <= F_DIVW;
        F_DIVW: begin
          if (div_done) begin
            op_q.bucket <= bucket;
            state_q     <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign push_o = (state_q == F_PUSH) && !full_i;
  assign op_o   = op_q;
endmodule

FILE: hw/rtl/lhsm_queue.sv
// Two-entry request queue between the front and back ends.
module lhsm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lhsm_pkg::lhsm_op_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output lhsm_pkg::lhsm_op_t data_o
);
  import lhsm_pkg::*;

  lhsm_op_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end
endmodule

FILE: hw/rtl/lhsm_back.sv
// Back end: per-phase statistics, histogram memory, percentile walk and result register.
module lhsm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        eff_width_i,
  input  logic               empty_i,
  input  lhsm_pkg::lhsm_op_t op_i,
  output logic               pop_o,
  output logic               init_done_o,
  lhsm_out_if.source         out_o
);
  import lhsm_pkg::*;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_PREP, B_RDIVS, B_RDIVW, B_MUL, B_QPREP, B_WALK, B_FIN
  } bstate_e;

  bstate_e state_q;

  logic [31:0]      count_q  [NUM_PHASES];
  logic [47:0]      total_q  [NUM_PHASES];
  logic [31:0]      min_q    [NUM_PHASES];
  logic [31:0]      max_q    [NUM_PHASES];
  logic [47:0]      mean_q   [NUM_PHASES];
  logic [63:0]      m2_q     [NUM_PHASES];
  logic [TOT_W-1:0] hist_tot_q [NUM_PHASES];

  lhsm_op_t         op_q;
  logic [31:0]      n_q;
  logic [47:0]      tq_q;
  logic             neg_q;
  logic [47:0]      dmag_q;
  logic [47:0]      mean_new_q;
  logic [47:0]      d2_q;
  logic [95:0]      acc_q;
  logic [1:0]       mul_cnt_q;
  logic [TOT_W+6:0] target_q;
  logic [TOT_W-1:0] cum_q;
  logic [BKT_W:0]   walk_cnt_q;
  logic             chk_vld_q;
  logic [BKT_W-1:0] chk_idx_q;
  logic [BKT_W-1:0] hit_idx_q;
  logic [HIST_AW-1:0] clr_cnt_q;

  logic        out_valid_q;
  logic [31:0] o_count_q, o_min_q, o_max_q, o_pct_q;
  logic [47:0] o_total_q, o_mean_q;
  logic [63:0] o_m2_q;

  logic [PHASE_W-1:0] ph;
  logic               take_out;
  logic               fin_go;

  // divider
  logic               div_start;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic               div_done;
  logic [DIV_N_W-1:0] div_quo;
  logic [TOT_W+6:0]   tot_pct;

  // histogram memory
  logic               ram_we, ram_re;
  logic [HIST_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic               bkt_sat;

  // record arithmetic
  logic [31:0]  prep_n;
  logic [47:0]  prep_t, prep_mean;
  logic         prep_neg;
  logic [48:0]  q49;
  logic [49:0]  mean_sum;
  logic [47:0]  mean_new;
  logic [47:0]  d2mag;
  logic [23:0]  a_half, b_half;
  logic [47:0]  pp;
  logic [95:0]  pp_sh;
  logic [96:0]  rnd;
  logic [63:0]  m2_add;
  logic [64:0]  m2_sum;
  logic [63:0]  m2_new;
  logic [48:0]  tot_sum;
  logic [47:0]  tot_new;
  logic [TOT_W:0]   cum_next;
  logic [TOT_W+7:0] cum_x100;
  logic [BKT_W+15:0] pct_prod;

  assign ph       = op_q.phase;
  assign take_out = out_o.ready && out_valid_q;
  assign fin_go   = (state_q == B_FIN) && (!out_valid_q || out_o.ready);
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign init_done_o = state_q != B_CLEAR;

  always_comb begin
    prep_n    = (count_q[ph] == '1) ? count_q[ph] : count_q[ph] + 32'd1;
    prep_t    = {op_q.sample_time, 16'd0};
    prep_mean = mean_q[ph];
    prep_neg  = prep_t < prep_mean;
  end

  assign tot_pct   = (TOT_W+7)'(hist_tot_q[ph]) * (TOT_W+7)'(op_q.pct);
  assign div_start = state_q == B_RDIVS;
  assign div_num   = DIV_N_W'(49'(dmag_q) + 49'(n_q >> 1));
  assign div_den   = n_q;

  lhsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // mean update and second deviation
  always_comb begin
    q49      = div_quo[48:0];
    mean_sum = 50'(mean_q[ph]) + 50'(q49);
    if (neg_q) begin
      mean_new = (q49 > 49'(mean_q[ph])) ? 48'd0 : mean_q[ph] - q49[47:0];
    end else begin
      mean_new = (mean_sum[49:48] != 2'd0) ? '1 : mean_sum[47:0];
    end
    d2mag = (tq_q >= mean_new) ? tq_q - mean_new : mean_new - tq_q;
  end

  // one 24x24 partial product per cycle
  always_comb begin
    a_half = mul_cnt_q[1] ? dmag_q[47:24] : dmag_q[23:0];
    b_half = mul_cnt_q[0] ? d2_q[47:24] : d2_q[23:0];
    pp     = 48'(a_half) * 48'(b_half);
    case (mul_cnt_q)
      2'd0:    pp_sh = 96'(pp);
      2'd3:    pp_sh = 96'(pp) << 48;
      default: pp_sh = 96'(pp) << 24;
    endcase
  end

  always_comb begin
    rnd     = {1'b0, acc_q} + (97'd1 << 23);
    m2_add  = (rnd[96:88] != '0) ? '1 : rnd[87:24];
    m2_sum  = {1'b0, m2_q[ph]} + {1'b0, m2_add};
    m2_new  = m2_sum[64] ? '1 : m2_sum[63:0];
    tot_sum = {1'b0, total_q[ph]} + 49'(op_q.sample_time);
    tot_new = tot_sum[48] ? '1 : tot_sum[47:0];
    bkt_sat = ram_rdata == '1;
    cum_next = {1'b0, cum_q} + (TOT_W+1)'(ram_rdata);
    // cum >= floor(x / 100) exactly when 100 * cum + 99 >= x
    cum_x100 = (TOT_W+8)'(cum_next) * (TOT_W+8)'(PCT_SCALE) + (TOT_W+8)'(PCT_SCALE - 1);
    pct_prod = (BKT_W+16)'(hit_idx_q) * (BKT_W+16)'(eff_width_i);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hist_addr(ph, op_q.bucket);
    ram_wdata = bkt_sat ? ram_rdata : ram_rdata + 32'd1;
    ram_re    = 1'b0;
    ram_raddr = hist_addr(ph, op_q.bucket);
    if (state_q == B_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (fin_go && op_q.kind == OP_RECORD) begin
      ram_we = 1'b1;
    end
    if (state_q == B_PREP) begin
      ram_re = 1'b1;
    end else if (state_q == B_WALK && walk_cnt_q < (BKT_W+1)'(NUM_BUCKETS)) begin
      ram_re    = 1'b1;
      ram_raddr = hist_addr(ph, walk_cnt_q[BKT_W-1:0]);
    end
  end

  lhsm_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PHASES; i++) begin
        count_q[i]    <= '0;
        total_q[i]    <= '0;
        min_q[i]      <= '1;
        max_q[i]      <= '0;
        mean_q[i]     <= '0;
        m2_q[i]       <= '0;
        hist_tot_q[i] <= '0;
      end
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (take_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == HIST_AW'(HIST_DEPTH - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty_i) begin
            op_q <= op_i;
            unique case (op_i.kind)
              OP_RECORD: state_q <= B_PREP;
              OP_QUERY:  state_q <= B_QPREP;
              default:   state_q <= B_FIN;
            endcase
          end
        end
        B_PREP: begin
          n_q     <= prep_n;
          tq_q    <= prep_t;
          neg_q   <= prep_neg;
          dmag_q  <= prep_neg ? prep_mean - prep_t : prep_t - prep_mean;
          state_q <= B_RDIVS;
        end
        B_RDIVS: state_q <= B_RDIVW;
        B_RDIVW: begin
          if (div_done) begin
            mean_new_q <= mean_new;
            d2_q       <= d2mag;
            acc_q      <= '0;
            mul_cnt_q  <= 2'd0;
            state_q    <= B_MUL;
          end
        end
        B_MUL: begin
          acc_q     <= acc_q + pp_sh;
          mul_cnt_q <= mul_cnt_q + 2'd1;
          if (mul_cnt_q == 2'd3) begin
            state_q <= B_FIN;
          end
        end
        B_QPREP: begin
          target_q   <= tot_pct;
          cum_q      <= '0;
          walk_cnt_q <= '0;
          chk_vld_q  <= 1'b0;
          state_q    <= B_WALK;
        end
        B_WALK: begin
          // issue one read per cycle, check the bucket read last cycle
          if (walk_cnt_q < (BKT_W+1)'(NUM_BUCKETS)) begin
            walk_cnt_q <= walk_cnt_q + 1'b1;
            chk_idx_q  <= walk_cnt_q[BKT_W-1:0];
            chk_vld_q  <= 1'b1;
          end
          if (chk_vld_q) begin
            cum_q <= cum_next[TOT_W-1:0];
            if (cum_x100 >= (TOT_W+8)'(target_q) || chk_idx_q == BKT_W'(NUM_BUCKETS - 1)) begin
              hit_idx_q <= chk_idx_q;
              state_q   <= B_FIN;
            end
          end
        end
        B_FIN: begin
          if (fin_go) begin
            state_q     <= B_IDLE;
            o_pct_q     <= '0;
            case (op_q.kind)
              OP_RECORD: begin
                count_q[ph] <= n_q;
                total_q[ph] <= tot_new;
                min_q[ph]   <= (op_q.sample_time < min_q[ph]) ? op_q.sample_time : min_q[ph];
                max_q[ph]   <= (op_q.sample_time > max_q[ph]) ? op_q.sample_time : max_q[ph];
                mean_q[ph]  <= mean_new_q;
                m2_q[ph]    <= m2_new;
                if (!bkt_sat) begin
                  hist_tot_q[ph] <= hist_tot_q[ph] + 1'b1;
                end
                o_count_q <= n_q;
                o_total_q <= tot_new;
                o_min_q   <= (op_q.sample_time < min_q[ph]) ? op_q.sample_time : min_q[ph];
                o_max_q   <= (op_q.sample_time > max_q[ph]) ? op_q.sample_time : max_q[ph];
                o_mean_q  <= mean_new_q;
                o_m2_q    <= m2_new;
              end
              OP_QUERY: begin
                o_count_q <= count_q[ph];
                o_total_q <= total_q[ph];
                o_min_q   <= min_q[ph];
                o_max_q   <= max_q[ph];
                o_mean_q  <= mean_q[ph];
                o_m2_q    <= m2_q[ph];
                o_pct_q   <= (hist_tot_q[ph] == '0) ? 32'd0 : 32'(pct_prod);
              end
              default: begin
                o_count_q <= '0;
                o_total_q <= '0;
                o_min_q   <= '1;
                o_max_q   <= '0;
                o_mean_q  <= '0;
                o_m2_q    <= '0;
              end
            endcase
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.sample_count    = o_count_q;
  assign out_o.time_total      = o_total_q;
  assign out_o.time_min        = o_min_q;
  assign out_o.time_max        = o_max_q;
  assign out_o.mean_q16        = o_mean_q;
  assign out_o.sq_dev_sum_q8   = o_m2_q;
  assign out_o.percentile_time = o_pct_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> !pop_o)
    else $error("queue popped during histogram clear");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == B_RDIVW))
    else $error("divider finished outside a wait state");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_FIN))
    else $error("result raised outside the finish step");
endmodule

FILE: hw/rtl/latency_histogram_stats_monitor.sv
// Top level of the latency histogram statistics monitor with its register port.
//
// Pause-time monitor for three phases. Each request records a sample or asks for a
// percentile and returns one result with the phase's count, total, min, max, Q32.16
// mean and Q56.8 sum of squared deviations. A record passes the bucket divide in the
// front end and then the mean divide and four partial products in the back end; the
// two ends overlap, so the front end can divide the next record while the back end
// works on the last one. A query forms the target in one step, then reads the
// histogram memory one bucket at a time until the target is met or the last bucket
// is reached. A request for phase three skips all of this. A stalled result holds
// the back end; the two-entry queue lets the front keep accepting until it fills.
// After reset the histogram memory is cleared one entry per cycle, all
// 3 * NUM_BUCKETS entries, and no request is accepted until it finishes; register
// writes are taken throughout. bucket_width lies at byte address 0.
module latency_histogram_stats_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  lhsm_in_if.sink     in_i,
  lhsm_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lhsm_pkg::*;

  logic [15:0] bucket_width_q;
  logic [15:0] eff_w;
  logic        cfg_wr;
  logic        init_done;
  logic        push, full, pop, empty;
  lhsm_op_t    push_op, pop_op;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUCKET_WIDTH);
  assign prdata = (paddr[2] == REG_BUCKET_WIDTH) ? {16'd0, bucket_width_q} : 32'd0;
  assign eff_w  = eff_width(bucket_width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_width_q <= 16'd1;
    end else if (cfg_wr) begin
      bucket_width_q <= pwdata[15:0];
    end
  end

  lhsm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_done_i(init_done),
    .eff_width_i(eff_w),
    .in_i       (in_i),
    .push_o     (push),
    .op_o       (push_op),
    .full_i     (full)
  );

  lhsm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_op),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (pop_op)
  );

  lhsm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .eff_width_i(eff_w),
    .empty_i    (empty),
    .op_i       (pop_op),
    .pop_o      (pop),
    .init_done_o(init_done),
    .out_o      (out_o)
  );
endmodule

FILE: tb/sv/lhsm_stats_checker.sv
// Checker: watches both channels, predicts the phase statistics and compares each result.
module lhsm_stats_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] bucket_width_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_action_i,
  input  logic [1:0]  in_phase_i,
  input  logic [31:0] in_time_i,
  input  logic [6:0]  in_pct_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_count_i,
  input  logic [47:0] out_total_i,
  input  logic [31:0] out_min_i,
  input  logic [31:0] out_max_i,
  input  logic [47:0] out_mean_i,
  input  logic [63:0] out_m2_i,
  input  logic [31:0] out_pctl_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);
  import lhsm_pkg::*;

  typedef struct packed {
    logic [31:0] count;
    logic [47:0] total;
    logic [31:0] tmin;
    logic [31:0] tmax;
    logic [47:0] mean;
    logic [63:0] m2;
    logic [31:0] pctl;
  } phase_stats_t;

  phase_stats_t stats_want_q[$];
  logic [31:0]  count_r [NUM_PHASES];
  logic [47:0]  total_r [NUM_PHASES];
  logic [31:0]  min_r   [NUM_PHASES];
  logic [31:0]  max_r   [NUM_PHASES];
  logic [47:0]  mean_r  [NUM_PHASES];
  logic [63:0]  m2_r    [NUM_PHASES];
  logic [31:0]  hist_r  [NUM_PHASES][NUM_BUCKETS];

  assign pending_o = stats_want_q.size();

  function automatic logic [63:0] dev_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + 128'(1) << 0;
    p = 128'(a) * 128'(b) + (128'(1) << 23);
    p = p >> 24;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  task automatic record_sample(int p, logic [31:0] t);
    logic [63:0] w, idx, n, tt, mean, dmag, q, d2mag, add;
    logic [64:0] s;
    logic neg;
    w = (bucket_width_i == 0) ? 64'd1 : 64'(bucket_width_i);
    idx = (2 * 64'(t) + w) / (2 * w);
    if (count_r[p] != '1) count_r[p]++;
    n = 64'(count_r[p]);
    tt = 64'(t) << 16;
    mean = 64'(mean_r[p]);
    neg = tt < mean;
    dmag = neg ? mean - tt : tt - mean;
    q = (dmag + n / 2) / n;
    if (neg) mean = (q > mean) ? 0 : mean - q;
    else mean = mean + q;
    if (mean > 64'hFFFF_FFFF_FFFF) mean = 64'hFFFF_FFFF_FFFF;
    mean_r[p] = mean[47:0];
    d2mag = (tt >= mean) ? tt - mean : mean - tt;
    add = dev_product(dmag, d2mag);
    s = 65'(m2_r[p]) + 65'(add);
    m2_r[p] = s[64] ? '1 : s[63:0];
    s = 65'(total_r[p]) + 65'(t);
    total_r[p] = (s > 65'hFFFF_FFFF_FFFF) ? '1 : s[47:0];
    if (t > max_r[p]) max_r[p] = t;
    if (t < min_r[p]) min_r[p] = t;
    if (idx >= NUM_BUCKETS) idx = NUM_BUCKETS - 1;
    if (hist_r[p][idx] != '1) hist_r[p][idx]++;
  endtask

  function automatic logic [31:0] percentile_of(int p, logic [6:0] pct);
    logic [63:0] sum, target, cum, w;
    sum = 0;
    cum = 0;
    w = (bucket_width_i == 0) ? 64'd1 : 64'(bucket_width_i);
    for (int i = 0; i < NUM_BUCKETS; i++) sum += 64'(hist_r[p][i]);
    if (sum == 0) return 0;
    target = sum * 64'(pct) / 100;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      cum += 64'(hist_r[p][i]);
      if (cum >= target) return 32'(64'(i) * w);
    end
    return 32'(64'(NUM_BUCKETS - 1) * w);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    phase_stats_t want, got;
    int p;
    if (!rst_ni) begin
      stats_want_q.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
      for (int i = 0; i < NUM_PHASES; i++) begin
        count_r[i] = 0; total_r[i] = 0; min_r[i] = '1; max_r[i] = 0;
        mean_r[i] = 0; m2_r[i] = 0;
        for (int j = 0; j < NUM_BUCKETS; j++) hist_r[i][j] = 0;
      end
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{out_count_i, out_total_i, out_min_i, out_max_i, out_mean_i, out_m2_i,
                out_pctl_i};
        results_seen_o <= results_seen_o + 1;
        if (stats_want_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = stats_want_q.pop_front();
          if (want !== got) begin
            $display("%0t: result mismatch expected cnt=%h tot=%h min=%h max=%h mean=%h m2=%h pt=%h",
                     $realtime, want.count, want.total, want.tmin, want.tmax, want.mean,
                     want.m2, want.pctl);
            $display("%0t:                 actual cnt=%h tot=%h min=%h max=%h mean=%h m2=%h pt=%h",
                     $realtime, got.count, got.total, got.tmin, got.tmax, got.mean,
                     got.m2, got.pctl);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        p = int'(in_phase_i);
        if (p >= NUM_PHASES) begin
          want = '{32'd0, 48'd0, '1, 32'd0, 48'd0, 64'd0, 32'd0};
        end else begin
          want.pctl = 0;
          if (in_action_i == 1'b0) record_sample(p, in_time_i);
          else want.pctl = percentile_of(p, in_pct_i);
          want.count = count_r[p]; want.total = total_r[p]; want.tmin = min_r[p];
          want.tmax = max_r[p]; want.mean = mean_r[p]; want.m2 = m2_r[p];
        end
        stats_want_q.push_back(want);
      end
    end
  end
endmodule

FILE: tb/sv/latency_histogram_stats_monitor_tb.sv
// Testbench top: drives requests and register writes, gives the verdict.
module latency_histogram_stats_monitor_tb;
  import lhsm_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [15:0] width_shadow = 16'd1;
  logic        sink_busy = 1'b0;
  int          fail_count, pending, results_seen, cycle_count = 0;
  int          idle_pct = 31;

  lhsm_in_if  req_ch ();
  lhsm_out_if res_ch ();

  latency_histogram_stats_monitor dut (
    .clk_i, .rst_ni, .in_i(req_ch.sink), .out_o(res_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lhsm_stats_checker checker_u (
    .clk_i, .rst_ni, .bucket_width_i(width_shadow),
    .in_valid_i(req_ch.valid), .in_ready_i(req_ch.ready), .in_action_i(req_ch.action),
    .in_phase_i(req_ch.phase), .in_time_i(req_ch.sample_time),
    .in_pct_i(req_ch.percentile_pct),
    .out_valid_i(res_ch.valid), .out_ready_i(res_ch.ready),
    .out_count_i(res_ch.sample_count), .out_total_i(res_ch.time_total),
    .out_min_i(res_ch.time_min), .out_max_i(res_ch.time_max),
    .out_mean_i(res_ch.mean_q16), .out_m2_i(res_ch.sq_dev_sum_q8),
    .out_pctl_i(res_ch.percentile_time),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_ch.valid = 1'b0; req_ch.action = 1'b0; req_ch.phase = '0;
    req_ch.sample_time = '0; req_ch.percentile_pct = '0;
    res_ch.ready = 1'b0;
  end

  // stall the result side at random, except during the no-idle stretch
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    res_ch.ready <= ($urandom_range(99) >= idle_pct);
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_width(logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(REG_BUCKET_WIDTH) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    width_shadow <= val[15:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_request(logic act, logic [1:0] ph, logic [31:0] t, logic [6:0] pct);
    @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    req_ch.valid <= 1'b1; req_ch.action <= act; req_ch.phase <= ph;
    req_ch.sample_time <= t; req_ch.percentile_pct <= pct;
    do @(posedge clk_i); while (!req_ch.ready);
    req_ch.valid <= 1'b0;
  endtask

  task automatic drain_and_settle();
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_pause(logic [15:0] w);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(70 * int'((w == 0) ? 16'd1 : w));
    endcase
  endfunction

  initial begin
    logic [15:0] widths [6];
    logic act;
    widths = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd250, 16'd1000};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_width(32'd3);
    // directed: extremes, both operations, invalid phase, empty and overshoot queries
    send_request(1'b1, 2'd0, 32'd0, 7'd50);
    send_request(1'b0, 2'd3, 32'hFFFF_FFFF, 7'd127);
    send_request(1'b1, 2'd3, 32'd5, 7'd0);
    send_request(1'b0, 2'd0, 32'd0, 7'd0);
    send_request(1'b0, 2'd0, 32'hFFFF_FFFF, 7'h7F);
    send_request(1'b0, 2'd0, 32'd4, 7'd0);
    send_request(1'b0, 2'd1, 32'h5555_5555, 7'd0);
    send_request(1'b0, 2'd1, 32'hAAAA_AAAA, 7'd0);
    send_request(1'b0, 2'd2, 32'd1, 7'd0);
    send_request(1'b0, 2'd2, 32'd2, 7'd0);
    for (int pc = 0; pc <= 127; pc += 25) send_request(1'b1, 2'd0, 32'd0, 7'(pc));
    send_request(1'b1, 2'd0, 32'd0, 7'd100);
    send_request(1'b1, 2'd0, 32'd0, 7'd127);
    send_request(1'b1, 2'd1, 32'd0, 7'd1);
    send_request(1'b1, 2'd2, 32'd0, 7'd99);
    drain_and_settle();
    for (int ph = 0; ph < 6; ph++) begin
      write_width({16'hFFFF, widths[ph]});
      idle_pct = (ph == 3) ? 0 : 31;
      for (int i = 0; i < 300; i++) begin
        act = ($urandom_range(99) < 30);
        send_request(act, ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
                     random_pause(widths[ph]), 7'($urandom_range(127)));
      end
      drain_and_settle();
    end
    $display("covered %0d results over six bucket widths incl. 0 and 65535,", results_seen);
    $display("records, queries, idle phase three and percentiles up to 127");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
